>>> src/pfe_pkg.sv
package pfe_pkg;

  // Defaults for the top-level parameters.
  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Width of the result field, and the width that a stack value is
  // sign-extended to before the result field is cut from it.
  localparam int RESULT_WIDTH = 32;
  localparam int EXT_WIDTH    = 64;

  // ASCII codes the evaluator recognizes.
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       ends_expression;
  } req_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] result_value;
    logic                           divide_by_zero;
    logic                           stack_overflow;
  } res_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_OTHER
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FLUSH,
    S_POP_RHS,
    S_POP_LHS,
    S_CAP_LHS,
    S_EXEC,
    S_ITER,
    S_PUSH_RES,
    S_END_POP,
    S_EMIT
  } state_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_end;
    logic is_digit;
    logic is_space;
    op_t  op;
    logic in_number;
    logic rhs_zero;
    logic md_done;
    logic out_busy;
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;
    logic digit_acc;
    logic push_num;
    logic push_res;
    logic pop;
    logic cap_rhs;
    logic cap_lhs;
    logic exec;
    logic cap_md;
    logic emit;
  } cmd_t;

  function automatic op_t decode_op(input logic [7:0] c);
    op_t op;
    case (c)
      CHAR_PLUS:  op = OP_ADD;
      CHAR_MINUS: op = OP_SUB;
      CHAR_STAR:  op = OP_MUL;
      CHAR_SLASH: op = OP_DIV;
      default:    op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

>>> src/pfe_ram.sv
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/pfe_muldiv.sv
module pfe_muldiv #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             is_div,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] result,
  output logic             done
);

  localparam int CNTW = $clog2(WIDTH);

  logic             busy;
  logic [CNTW-1:0]  cnt;
  logic             is_div_r;
  logic             neg;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH:0]   p;

  logic             a_neg;
  logic             b_neg;
  logic [WIDTH-1:0] ua;
  logic [WIDTH-1:0] ub;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] mul_sum;

  // Division works on magnitudes; the sign is applied to the quotient at the end.
  assign a_neg   = a[WIDTH-1];
  assign b_neg   = b[WIDTH-1];
  assign ua      = a_neg ? (~a + 1'b1) : a;
  assign ub      = b_neg ? (~b + 1'b1) : b;
  assign trial   = {p[WIDTH-1:0], x[WIDTH-1]};
  assign diff    = trial - {1'b0, y};
  assign fits    = (trial >= {1'b0, y});
  assign mul_sum = p[WIDTH-1:0] + (y[0] ? x : '0);
  assign result  = is_div_r ? (neg ? (~x + 1'b1) : x) : p[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNTW'(WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      is_div_r <= is_div;
      neg      <= a_neg ^ b_neg;
      x        <= is_div ? ua : a;
      y        <= is_div ? ub : b;
      p        <= '0;
    end else if (busy) begin
      if (is_div_r) begin
        // Restoring division, one quotient bit per cycle.
        p <= fits ? diff : trial;
        x <= {x[WIDTH-2:0], fits};
      end else begin
        // Shift-and-add multiply, one multiplier bit per cycle.
        p <= {1'b0, mul_sum};
        x <= x << 1;
        y <= y >> 1;
      end
    end
  end

endmodule

>>> src/pfe_ctrl.sv
module pfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pfe_pkg::status_t  status,
  output pfe_pkg::cmd_t     cmd
);

  pfe_pkg::state_t state;
  pfe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pfe_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = pfe_pkg::S_DECODE;
        end
      end
      pfe_pkg::S_DECODE: begin
        if (status.item_end) begin
          state_next = status.in_number ? pfe_pkg::S_FLUSH : pfe_pkg::S_END_POP;
        end else if (status.is_digit) begin
          state_next = pfe_pkg::S_IDLE;
        end else if (status.in_number) begin
          state_next = pfe_pkg::S_FLUSH;
        end else if (status.is_space) begin
          state_next = pfe_pkg::S_IDLE;
        end else begin
          state_next = pfe_pkg::S_POP_RHS;
        end
      end
      pfe_pkg::S_FLUSH: begin
        if (status.item_end) begin
          state_next = pfe_pkg::S_END_POP;
        end else if (status.is_space) begin
          state_next = pfe_pkg::S_IDLE;
        end else begin
          state_next = pfe_pkg::S_POP_RHS;
        end
      end
      pfe_pkg::S_POP_RHS: state_next = pfe_pkg::S_POP_LHS;
      pfe_pkg::S_POP_LHS: state_next = pfe_pkg::S_CAP_LHS;
      pfe_pkg::S_CAP_LHS: begin
        state_next = (status.op == pfe_pkg::OP_OTHER) ? pfe_pkg::S_IDLE : pfe_pkg::S_EXEC;
      end
      pfe_pkg::S_EXEC: begin
        if (status.op == pfe_pkg::OP_MUL ||
            (status.op == pfe_pkg::OP_DIV && !status.rhs_zero)) begin
          state_next = pfe_pkg::S_ITER;
        end else begin
          state_next = pfe_pkg::S_PUSH_RES;
        end
      end
      pfe_pkg::S_ITER: begin
        if (status.md_done) begin
          state_next = pfe_pkg::S_PUSH_RES;
        end
      end
      pfe_pkg::S_PUSH_RES: state_next = pfe_pkg::S_IDLE;
      pfe_pkg::S_END_POP:  state_next = pfe_pkg::S_EMIT;
      pfe_pkg::S_EMIT: begin
        if (!status.out_busy) begin
          state_next = pfe_pkg::S_IDLE;
        end
      end
      default: state_next = pfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      pfe_pkg::S_IDLE: begin
        req_ready     = 1'b1;
        cmd.take_item = req_valid;
      end
      pfe_pkg::S_DECODE: begin
        cmd.digit_acc = !status.item_end && status.is_digit;
      end
      pfe_pkg::S_FLUSH:    cmd.push_num = 1'b1;
      pfe_pkg::S_POP_RHS:  cmd.pop = 1'b1;
      pfe_pkg::S_POP_LHS: begin
        cmd.cap_rhs = 1'b1;
        cmd.pop     = 1'b1;
      end
      pfe_pkg::S_CAP_LHS:  cmd.cap_lhs = 1'b1;
      pfe_pkg::S_EXEC:     cmd.exec = 1'b1;
      pfe_pkg::S_ITER:     cmd.cap_md = status.md_done;
      pfe_pkg::S_PUSH_RES: cmd.push_res = 1'b1;
      pfe_pkg::S_END_POP:  cmd.pop = 1'b1;
      pfe_pkg::S_EMIT:     cmd.emit = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/pfe_datapath.sv
module pfe_datapath #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pfe_pkg::req_t    req_data,
  input  pfe_pkg::cmd_t    cmd,
  output pfe_pkg::status_t status,
  output logic             res_valid,
  input  logic             res_ready,
  output pfe_pkg::res_t    res_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  pfe_pkg::req_t          item;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] acc;
  logic                   in_number;
  logic                   div0_flag;
  logic                   ovf_flag;
  logic                   rd_hit;
  logic [VALUE_WIDTH-1:0] rhs;
  logic [VALUE_WIDTH-1:0] lhs;
  logic [VALUE_WIDTH-1:0] res;

  pfe_pkg::op_t           op;
  logic                   count_zero;
  logic                   count_full;
  logic [CW-1:0]          count_m1;
  logic                   push;
  logic                   ram_we;
  logic                   ram_re;
  logic [VALUE_WIDTH-1:0] push_val;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] popped;
  logic [7:0]             digit_off;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic                   md_start;
  logic [VALUE_WIDTH-1:0] md_result;
  logic                   md_done;
  logic signed [VALUE_WIDTH-1:0]        top_s;
  logic signed [pfe_pkg::EXT_WIDTH-1:0] top_ext;

  assign op         = pfe_pkg::decode_op(item.char_code);
  assign count_zero = (count == '0);
  assign count_full = (count == CW'(STACK_DEPTH));
  assign count_m1   = count - 1'b1;
  assign push       = cmd.push_num | cmd.push_res;
  assign push_val   = cmd.push_num ? acc : res;
  assign ram_we     = push && !count_full;
  assign ram_re     = cmd.pop && !count_zero;
  assign popped     = rd_hit ? rdata : '0;

  // Next digit: acc * 10 + digit, wrapping at the value width.
  assign digit_off = item.char_code - pfe_pkg::CHAR_ZERO;
  assign acc_next  = (acc << 3) + (acc << 1) + VALUE_WIDTH'(digit_off[3:0]);

  assign md_start = cmd.exec &&
                    (op == pfe_pkg::OP_MUL || (op == pfe_pkg::OP_DIV && rhs != '0));

  assign top_s   = popped;
  assign top_ext = pfe_pkg::EXT_WIDTH'(top_s);

  always_comb begin
    status.item_end  = item.ends_expression;
    status.is_digit  = (item.char_code >= pfe_pkg::CHAR_ZERO) &&
                       (item.char_code <= pfe_pkg::CHAR_NINE);
    status.is_space  = (item.char_code == pfe_pkg::CHAR_SPACE);
    status.op        = op;
    status.in_number = in_number;
    status.rhs_zero  = (rhs == '0);
    status.md_done   = md_done;
    status.out_busy  = res_valid && !res_ready;
  end

  pfe_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(push_val),
    .re   (ram_re),
    .raddr(count_m1[AW-1:0]),
    .rdata(rdata)
  );

  pfe_muldiv #(
    .WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .is_div(op == pfe_pkg::OP_DIV),
    .a     (lhs),
    .b     (rhs),
    .result(md_result),
    .done  (md_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      acc       <= '0;
      in_number <= 1'b0;
      div0_flag <= 1'b0;
      ovf_flag  <= 1'b0;
      rd_hit    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.digit_acc) begin
        acc       <= acc_next;
        in_number <= 1'b1;
      end
      if (push) begin
        if (count_full) begin
          ovf_flag <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (cmd.push_num) begin
        acc       <= '0;
        in_number <= 1'b0;
      end
      if (cmd.pop) begin
        rd_hit <= !count_zero;
        if (!count_zero) begin
          count <= count_m1;
        end
      end
      if (cmd.exec && op == pfe_pkg::OP_DIV && rhs == '0) begin
        div0_flag <= 1'b1;
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
        count     <= '0;
        acc       <= '0;
        in_number <= 1'b0;
        div0_flag <= 1'b0;
        ovf_flag  <= 1'b0;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= req_data;
    end
    if (cmd.cap_rhs) begin
      rhs <= popped;
    end
    if (cmd.cap_lhs) begin
      lhs <= popped;
    end
    if (cmd.exec) begin
      case (op)
        pfe_pkg::OP_ADD: res <= lhs + rhs;
        pfe_pkg::OP_SUB: res <= lhs - rhs;
        default:         res <= '0;
      endcase
    end
    if (cmd.cap_md) begin
      res <= md_result;
    end
    if (cmd.emit) begin
      res_data.result_value   <= top_ext[pfe_pkg::RESULT_WIDTH-1:0];
      res_data.divide_by_zero <= div0_flag;
      res_data.stack_overflow <= ovf_flag;
    end
  end

endmodule

>>> src/postfix_expression_evaluator.sv
// Postfix expression evaluator: each request carries one ASCII character, and a request with
// ends_expression set closes the expression and yields one result holding the popped top of
// the operand stack (0 if it is empty) with sticky divide-by-zero and stack-overflow flags.
// Requests are handled one at a time by a controller state machine that steps a datapath built
// around a single-port-per-side stack RAM and a shared iterative multiply/divide unit. * and /
// run through that unit, one bit per cycle, but a division by zero skips it. The end marker
// emits into an output register, so the next request is taken while the result waits; a
// second end marker stalls only if the earlier result is still not taken. The stack needs no
// clearing after reset: only entries below the count are ever read.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pfe_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output pfe_pkg::res_t res_data
);

  // Command and status between the sequencer and the datapath.
  pfe_pkg::cmd_t    cmd;
  pfe_pkg::status_t status;

  // The controller decides one step per cycle from the decoded character class and the datapath status.
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the stack, the number being built, the operands and the result register.
  pfe_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .status   (status),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

endmodule

>>> src/pfe_checker.sv
module pfe_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          res_valid,
  input logic          res_ready,
  input pfe_pkg::res_t res_data
);

  // A waiting result stays and does not change until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // Requests are handled one at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // A result never rises right after its request is accepted.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_valid && req_ready))
    else $error("result appeared right after a request");

endmodule

bind postfix_expression_evaluator pfe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res_data (res_data)
);

>>> dv/postfix_expression_evaluator_test.sv
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;

  // Run shape. The watchdog limit is far above what the slowest legal run needs:
  // about 1200 requests plus random gaps on both sides.
  localparam int STACK_SLOTS   = pfe_pkg::STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int IDLE_PERCENT  = 38;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // Character codes used by the stimulus beyond the ones the package names.
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_TOP_CODE = 8'hFF;

  // Results that can be read straight off the expression.
  localparam pfe_pkg::res_t EMPTY_RESULT     = '{32'sd0, 1'b0, 1'b0};
  localparam pfe_pkg::res_t DIV_ZERO_RESULT  = '{32'sd0, 1'b1, 1'b0};
  localparam pfe_pkg::res_t SIX_RESULT       = '{32'sd6, 1'b0, 1'b0};
  localparam pfe_pkg::res_t MINUS_ONE_RESULT = '{-32'sd1, 1'b0, 1'b0};

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  pfe_pkg::req_t req_data  = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  pfe_pkg::res_t res_data;

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_SLOTS),
    .VALUE_WIDTH(pfe_pkg::VALUE_WIDTH_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  always #6 clk = ~clk;

  // Bookkeeping shared by the request driver, the result checker and the watchdog.
  pfe_pkg::res_t pending_results[$];
  pfe_pkg::req_t stim_q[$];
  int   cycle_count        = 0;
  int   mismatch_count     = 0;
  int   items_sent         = 0;
  int   expressions_closed = 0;
  int   results_checked    = 0;
  int   div_zero_results   = 0;
  int   overflow_results   = 0;
  bit   steady_flow        = 1'b0;

  // ---------------------------------------------------------------------------
  // Evaluator mirror. It keeps its own operand stack, the digit run being built
  // and the two sticky error flags, and advances once per accepted request.
  // ---------------------------------------------------------------------------
  logic [31:0] mirror_stack [STACK_SLOTS];
  int unsigned mirror_depth;
  logic [31:0] digit_value;
  bit          digit_open;
  bit          saw_div_zero;
  bit          saw_overflow;

  function automatic void clear_evaluator();
    mirror_depth = 0;
    digit_value  = '0;
    digit_open   = 1'b0;
    saw_div_zero = 1'b0;
    saw_overflow = 1'b0;
  endfunction

  // A push onto a full stack is lost, but the expression remembers it.
  function automatic void push_operand(input logic [31:0] value);
    if (mirror_depth >= STACK_SLOTS) begin
      saw_overflow = 1'b1;
    end else begin
      mirror_stack[mirror_depth] = value;
      mirror_depth++;
    end
  endfunction

  // Popping an empty stack yields zero and leaves the depth at zero.
  function automatic logic [31:0] pop_operand();
    if (mirror_depth == 0) return '0;
    mirror_depth--;
    return mirror_stack[mirror_depth];
  endfunction

  function automatic void close_number();
    if (digit_open) begin
      push_operand(digit_value);
      digit_value = '0;
      digit_open  = 1'b0;
    end
  endfunction

  // Division on magnitudes so that the most negative value over minus one wraps
  // back to itself instead of trapping, and the quotient truncates toward zero.
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] lhs,
                                                       input logic [31:0] rhs);
    logic [31:0] mag_lhs;
    logic [31:0] mag_rhs;
    logic [31:0] mag_q;
    mag_lhs = lhs[31] ? -lhs : lhs;
    mag_rhs = rhs[31] ? -rhs : rhs;
    mag_q   = mag_lhs / mag_rhs;
    return (lhs[31] != rhs[31]) ? -mag_q : mag_q;
  endfunction

  // Advances the mirror by one request. Returns 1 when the request closes the
  // expression, with the predicted result in outcome.
  function automatic bit evaluate_char(input pfe_pkg::req_t request,
                                       output pfe_pkg::res_t outcome);
    logic [31:0] rhs;
    logic [31:0] lhs;
    outcome = '0;
    if (request.ends_expression) begin
      // An open digit run is pushed before the top is taken.
      close_number();
      outcome.result_value   = pop_operand();
      outcome.divide_by_zero = saw_div_zero;
      outcome.stack_overflow = saw_overflow;
      clear_evaluator();
      return 1'b1;
    end
    if (request.char_code >= pfe_pkg::CHAR_ZERO && request.char_code <= pfe_pkg::CHAR_NINE) begin
      digit_value = digit_value * 32'd10 + 32'(request.char_code - pfe_pkg::CHAR_ZERO);
      digit_open  = 1'b1;
      return 1'b0;
    end
    close_number();
    if (request.char_code == pfe_pkg::CHAR_SPACE) return 1'b0;
    // Every other character consumes two operands; unknown ones push nothing.
    rhs = pop_operand();
    lhs = pop_operand();
    case (request.char_code)
      pfe_pkg::CHAR_PLUS:  push_operand(lhs + rhs);
      pfe_pkg::CHAR_MINUS: push_operand(lhs - rhs);
      pfe_pkg::CHAR_STAR:  push_operand(lhs * rhs);
      pfe_pkg::CHAR_SLASH: begin
        if (rhs == '0) begin
          saw_div_zero = 1'b1;
          push_operand('0);
        end else begin
          push_operand(quotient_toward_zero(lhs, rhs));
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking. Only the first few mismatches are printed in full.
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, what);
  endfunction

  function automatic void check_result(input pfe_pkg::res_t got);
    pfe_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d div0=%0b ovf=%0b arrived with none outstanding",
                                got.result_value, got.divide_by_zero, got.stack_overflow));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.divide_by_zero) div_zero_results++;
    if (want.stack_overflow) overflow_results++;
    if (got.result_value !== want.result_value)
      report_mismatch($sformatf("result %0d: result_value expected %0d, got %0d",
                                results_checked, want.result_value, got.result_value));
    if (got.divide_by_zero !== want.divide_by_zero)
      report_mismatch($sformatf("result %0d: divide_by_zero expected %0b, got %0b",
                                results_checked, want.divide_by_zero, got.divide_by_zero));
    if (got.stack_overflow !== want.stack_overflow)
      report_mismatch($sformatf("result %0d: stack_overflow expected %0b, got %0b",
                                results_checked, want.stack_overflow, got.stack_overflow));
  endfunction

  // Outputs are read right at the rising edge, so they still hold the values the
  // block presented for that edge; the block's own updates land afterwards.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) check_result(res_data);
  end

  // The result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    res_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. The optional gap drops valid for whole cycles; once valid
  // rises it holds with a fixed payload until the handshake completes. Each
  // time step sees a single assignment to valid.
  // ---------------------------------------------------------------------------
  task automatic send_request(input pfe_pkg::req_t request, input bit known,
                              input pfe_pkg::res_t known_result);
    pfe_pkg::res_t predicted;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= request;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    if (evaluate_char(request, predicted)) begin
      pending_results.push_back(known ? known_result : predicted);
      expressions_closed++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders. Each scenario appends a whole expression, end marker
  // included, to stim_q.
  // ---------------------------------------------------------------------------
  function automatic void add_char(input logic [7:0] code);
    pfe_pkg::req_t request;
    request.char_code       = code;
    request.ends_expression = 1'b0;
    stim_q.push_back(request);
  endfunction

  // The character field carries random junk on an end marker; it must be ignored.
  function automatic void add_end();
    pfe_pkg::req_t request;
    request.char_code       = 8'($urandom_range(0, 255));
    request.ends_expression = 1'b1;
    stim_q.push_back(request);
  endfunction

  function automatic void add_text(input string text);
    for (int i = 0; i < text.len(); i++) add_char(text[i]);
  endfunction

  // Mostly short numbers; zeros feed the divide-by-zero path and long runs wrap.
  function automatic void add_number();
    int unsigned pick;
    int unsigned digits;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      add_char(pfe_pkg::CHAR_ZERO);
    end else if (pick < 14) begin
      add_text($sformatf("%0d", $urandom()));
    end else if (pick < 16) begin
      add_text("4294967295");
    end else begin
      digits = (pick < 85) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      repeat (digits) add_char(pfe_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return pfe_pkg::CHAR_PLUS;
      1:       return pfe_pkg::CHAR_MINUS;
      2:       return pfe_pkg::CHAR_STAR;
      default: return pfe_pkg::CHAR_SLASH;
    endcase
  endfunction

  // A valid postfix expression with the given number of operators. A number is
  // pushed while there are operators left to absorb it, so the stack ends with
  // exactly one entry. Numbers that follow numbers need a separating space.
  function automatic void add_wellformed(input int unsigned operators);
    int unsigned depth;
    int unsigned ops_left;
    bit          after_number;
    depth        = 0;
    ops_left     = operators;
    after_number = 1'b0;
    do begin
      if (depth < 2 || (ops_left > depth - 1 && $urandom_range(0, 1) == 1)) begin
        if (after_number || $urandom_range(0, 7) == 0) add_char(pfe_pkg::CHAR_SPACE);
        add_number();
        depth++;
        after_number = 1'b1;
      end else begin
        add_char(random_operator());
        depth--;
        ops_left--;
        after_number = 1'b0;
        if ($urandom_range(0, 3) == 0) add_char(pfe_pkg::CHAR_SPACE);
      end
    end while (ops_left > 0);
    if ($urandom_range(0, 5) == 0) add_char(pfe_pkg::CHAR_SPACE);
  endfunction

  // Fixed corner expressions: the most negative value over minus one, wrap on
  // accumulation and on arithmetic, and truncation of negative quotients.
  function automatic void add_extreme();
    string corners [10] = '{"2147483648 0 1-/", "2147483648 1-", "4294967295 1+",
                            "4294967296", "99999999999 7/", "2147483648 2147483648*",
                            "65536 65536*", "0 7-3/", "7 0 3-/", "2147483647 2147483647+"};
    add_text(corners[$urandom_range(0, 9)]);
  endfunction

  function automatic void build_scenario();
    int unsigned   pick;
    int unsigned   first;
    int unsigned   spot;
    pfe_pkg::req_t junk;
    string         symbols;
    symbols = "0123456789+-*/ ";
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // Ordinary expressions, with an occasional deep one that overruns the stack.
      add_wellformed(($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                                 : $urandom_range(0, 6));
    end else if (pick < 65) begin
      // Flood the stack up to or past its depth, then fold some of it back.
      repeat ($urandom_range(STACK_SLOTS - 2, STACK_SLOTS + 8)) begin
        add_char(pfe_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        add_char(pfe_pkg::CHAR_SPACE);
      end
      repeat ($urandom_range(0, 5)) add_char(random_operator());
    end else if (pick < 72) begin
      add_extreme();
    end else if (pick < 88) begin
      // A valid expression with one character replaced, removed or inserted.
      first = stim_q.size();
      add_wellformed($urandom_range(1, 6));
      spot = $urandom_range(first, stim_q.size() - 1);
      junk.char_code       = 8'($urandom_range(0, 255));
      junk.ends_expression = 1'b0;
      case ($urandom_range(0, 2))
        0:       stim_q[spot] = junk;
        1:       stim_q.delete(spot);
        default: stim_q.insert(spot, junk);
      endcase
    end else begin
      // Raw noise over the whole code space, with stray end markers mixed in.
      repeat ($urandom_range(3, 20)) begin
        if ($urandom_range(0, 7) == 0) begin
          add_end();
        end else if ($urandom_range(0, 1) == 0) begin
          add_char(8'($urandom_range(0, 255)));
        end else begin
          add_char(symbols[$urandom_range(0, 14)]);
        end
      end
    end
    add_end();
  endfunction

  // ---------------------------------------------------------------------------
  // Directed opening. Rows whose result is obvious carry it; the rest rely on
  // the mirror.
  // ---------------------------------------------------------------------------
  typedef struct {
    pfe_pkg::req_t request;
    bit            known;
    pfe_pkg::res_t known_result;
  } directed_row_t;

  directed_row_t directed_rows [25] = '{
    // End marker on an empty stack gives zero.
    '{'{CHAR_NUL, 1'b1}, 1'b1, EMPTY_RESULT},
    // Division by zero pushes zero and raises the flag.
    '{'{pfe_pkg::CHAR_ZERO + 8'd5, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_SPACE, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_SLASH, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_SLASH, 1'b1}, 1'b1, DIV_ZERO_RESULT},
    // A code above the ASCII range discards both operands.
    '{'{pfe_pkg::CHAR_ZERO + 8'd7, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_SPACE, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO + 8'd3, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{CHAR_TOP_CODE, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO, 1'b1}, 1'b1, EMPTY_RESULT},
    // Subtract, multiply and add in one chain.
    '{'{pfe_pkg::CHAR_NINE, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_SPACE, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO + 8'd4, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_MINUS, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO + 8'd3, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_STAR, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO + 8'd2, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_PLUS, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{CHAR_TOP_CODE, 1'b1}, 1'b0, EMPTY_RESULT},
    // The end marker pushes an open number and ignores its own character.
    '{'{pfe_pkg::CHAR_ZERO + 8'd6, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_ZERO + 8'd7, 1'b1}, 1'b1, SIX_RESULT},
    // Subtracting with only one operand pops zero for the missing left side.
    '{'{pfe_pkg::CHAR_ZERO + 8'd1, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_MINUS, 1'b0}, 1'b0, EMPTY_RESULT},
    '{'{pfe_pkg::CHAR_PLUS, 1'b1}, 1'b1, MINUS_ONE_RESULT}
  };

  initial begin
    clear_evaluator();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].request, directed_rows[i].known,
                   directed_rows[i].known_result);

    // Random expressions until the request budget is spent. A stretch in the
    // middle runs with neither side idling.
    while (items_sent < $size(directed_rows) + RANDOM_ITEMS) begin
      steady_flow = (items_sent >= 500 && items_sent < 700);
      build_scenario();
      while (stim_q.size() != 0) send_request(stim_q.pop_front(), 1'b0, EMPTY_RESULT);
    end
    steady_flow = 1'b0;
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d expressions; %0d results checked, %0d mismatches.",
             items_sent, expressions_closed, results_checked, mismatch_count);
    $display("Results with divide by zero: %0d, with a dropped push: %0d.",
             div_zero_results, overflow_results);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
